### rtl/core/iale_pkg.sv
// Types and codes shared by the indexed array list engine.
package iale_pkg;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_INSERT     = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_POP_BACK   = 3'd4;
  localparam logic [2:0] OP_REMOVE     = 3'd5;
  localparam logic [2:0] OP_READ       = 3'd6;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [4:0]         position;
    logic signed [31:0] item_value;
  } iale_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
    logic [1:0]         status;
  } iale_out_t;

  // decoded request, broadcast to the cell row
  typedef struct packed {
    logic       up;      // open a gap at idx and load the word there
    logic       down;    // close the slot at idx
    logic       shrink;  // count drops by one
    logic       rd_en;   // read the entry at idx
    logic [1:0] status;
  } iale_dec_t;

endpackage

### rtl/core/iale_dec.sv
// Request decoder: range and full checks, shift direction and gap index.
module iale_dec #(
  parameter int CAPACITY = 16
) (
  input  logic [2:0]                        opcode,
  input  logic [4:0]                        position,
  input  logic [$clog2(CAPACITY+1)-1:0]     count,
  output iale_pkg::iale_dec_t               dec,
  output logic [$clog2(CAPACITY)-1:0]       idx
);
  import iale_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int XW = CW + 5;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] cap_x;
  logic          full;
  logic          empty;

  assign pos_x = XW'(position);
  assign cnt_x = XW'(count);
  assign cap_x = XW'(CAPACITY);
  assign full  = (cnt_x >= cap_x);
  assign empty = (count == '0);

  always_comb begin
    dec    = '0;
    idx    = '0;
    dec.status = ST_DONE;
    case (opcode)
      OP_PUSH_FRONT: begin
        if (full) begin
          dec.status = ST_FULL;
        end else begin
          dec.up = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          dec.status = ST_FULL;
        end else begin
          dec.up = 1'b1;
          idx    = count[AW-1:0];
        end
      end
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          dec.status = ST_RANGE;
        end else if (full) begin
          dec.status = ST_FULL;
        end else begin
          dec.up = 1'b1;
          idx    = pos_x[AW-1:0];
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          dec.status = ST_RANGE;
        end else begin
          dec.down   = 1'b1;
          dec.shrink = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          dec.status = ST_RANGE;
        end else begin
          dec.shrink = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos_x >= cnt_x) begin
          dec.status = ST_RANGE;
        end else begin
          dec.down   = 1'b1;
          dec.shrink = 1'b1;
          idx        = pos_x[AW-1:0];
        end
      end
      OP_READ: begin
        if (pos_x >= cnt_x) begin
          dec.status = ST_RANGE;
        end else begin
          dec.rd_en = 1'b1;
          idx       = pos_x[AW-1:0];
        end
      end
      default: begin
        dec.status = ST_RANGE;
      end
    endcase
  end

endmodule

### rtl/core/iale_cell.sv
// One list slot: holds a word, loads, or takes a neighbor's word on a shift.
module iale_cell #(
  parameter int AW  = 4,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                en,
  input  iale_pkg::iale_dec_t dec,
  input  logic [AW-1:0]       idx,
  input  logic [31:0]         word,
  input  logic [31:0]         left_data,
  input  logic [31:0]         right_data,
  output logic [31:0]         data_out,
  output logic [31:0]         rd_part
);
  import iale_pkg::*;

  localparam logic [AW-1:0] MY_IDX = AW'(IDX);

  logic [31:0] entry_r;
  logic [31:0] entry_nxt;
  logic        at_gap;
  logic        past_gap;

  assign at_gap   = (idx == MY_IDX);
  assign past_gap = (MY_IDX > idx);

  always_comb begin
    entry_nxt = entry_r;
    if (en && dec.up) begin
      if (at_gap) begin
        entry_nxt = word;
      end else if (past_gap) begin
        entry_nxt = left_data;
      end
    end else if (en && dec.down && (at_gap || past_gap)) begin
      entry_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign data_out = entry_r;
  assign rd_part  = (dec.rd_en && at_gap) ? entry_r : 32'd0;

endmodule

### rtl/core/indexed_array_list_engine.sv
// Indexed array list engine: top level with cell row, count and output buffer.
// Keeps an ordered list of up to CAPACITY signed 32-bit words in a row of
// register cells, one word per cell. Every request (push front/back, insert,
// pop front/back, remove, read) acts at the edge that accepts it: the cells
// past the index shift up or down together, so a new request can be taken
// every cycle while in_stall is low. The result word is registered into the
// output register, or the skid register if that is held; this two-deep buffer
// lets the input keep flowing for one extra word while the output is stalled.
// A read selects its cell through an AND-OR combine across the row, which sets
// the longest path for large CAPACITY. No clearing pass is needed after reset.
module indexed_array_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  iale_pkg::iale_in_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output iale_pkg::iale_out_t out_word
);
  import iale_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            skid_valid_r;
  logic            skid_valid_nxt;
  iale_out_t       out_word_r;
  iale_out_t       out_word_nxt;
  iale_out_t       skid_word_r;
  iale_out_t       skid_word_nxt;

  iale_dec_t       dec;
  logic [AW-1:0]   idx;
  logic            in_acc;
  logic            out_pop;
  iale_out_t       result;
  logic [CW+4:0]   cnt_ext;
  logic [31:0]     rd_value;

  logic [31:0]     cell_data [CAPACITY];
  logic [31:0]     cell_rd   [CAPACITY];

  iale_dec #(
    .CAPACITY(CAPACITY)
  ) u_dec (
    .opcode   (in_word.opcode),
    .position (in_word.position),
    .count    (count_r),
    .dec      (dec),
    .idx      (idx)
  );

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_pop  = out_valid_r && !out_stall;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [31:0] left_in;
    logic [31:0] right_in;
    if (k == 0) begin : g_first
      assign left_in = 32'd0;
    end else begin : g_left
      assign left_in = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_in = 32'd0;
    end else begin : g_right
      assign right_in = cell_data[k+1];
    end
    iale_cell #(
      .AW  (AW),
      .IDX (k)
    ) u_cell (
      .clk        (clk),
      .en         (in_acc),
      .dec        (dec),
      .idx        (idx),
      .word       (in_word.item_value),
      .left_data  (left_in),
      .right_data (right_in),
      .data_out   (cell_data[k]),
      .rd_part    (cell_rd[k])
    );
  end

  always_comb begin
    rd_value = 32'd0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_value = rd_value | cell_rd[k];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (in_acc && dec.up) begin
      count_nxt = count_r + CW'(1);
    end else if (in_acc && dec.shrink) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign cnt_ext            = {5'd0, count_nxt};
  assign result.read_value  = rd_value;
  assign result.entry_count = cnt_ext[4:0];
  assign result.status      = dec.status;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    skid_valid_nxt = skid_valid_r;
    skid_word_nxt  = skid_word_r;
    if (skid_valid_r) begin
      if (out_pop) begin
        out_word_nxt   = skid_word_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_pop) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = result;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_word_nxt  = result;
      end
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTH
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held while output register empty");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && dec.status != ST_DONE) |=> count_r == $past(count_r))
    else $error("rejected request changed the count");

  a_read_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.read_value != 32'd0) |-> out_word_r.status == ST_DONE)
    else $error("nonzero read value on a failed request");

  a_full_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && dec.status == ST_FULL) |-> count_r == CW'(CAPACITY))
    else $error("full status below capacity");
`endif

endmodule

### tb/iale_result_checker.sv
// Checker for the indexed array list engine: tracks the list, predicts each result and compares.
module iale_result_checker #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  iale_pkg::iale_in_t  in_word,
  input  logic                out_valid,
  input  logic                out_stall,
  input  iale_pkg::iale_out_t out_word,
  output int                  mismatches,
  output int                  outstanding,
  output int                  held_size
);
  import iale_pkg::*;

  logic signed [31:0] held [CAPACITY];
  int                 held_count = 0;
  iale_out_t          expected_results[$];
  int                 errs = 0;

  function automatic iale_out_t apply_list_request(input iale_in_t w);
    iale_out_t r;
    int        at;
    int        j;
    r = '0;
    r.status = ST_DONE;
    case (w.opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
        if (w.opcode == OP_PUSH_FRONT) at = 0;
        else if (w.opcode == OP_PUSH_BACK) at = held_count;
        else at = w.position;
        // index check comes before the full check
        if (at > held_count) begin
          r.status = ST_RANGE;
        end else if (held_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (j = held_count; j > at; j--) held[j] = held[j-1];
          held[at] = w.item_value;
          held_count++;
        end
      end
      OP_POP_FRONT, OP_REMOVE: begin
        at = (w.opcode == OP_POP_FRONT) ? 0 : w.position;
        if (at >= held_count) begin
          r.status = ST_RANGE;
        end else begin
          for (j = at; j + 1 < held_count; j++) held[j] = held[j+1];
          held_count--;
        end
      end
      OP_POP_BACK: begin
        if (held_count == 0) r.status = ST_RANGE;
        else held_count--;
      end
      OP_READ: begin
        if (w.position >= held_count) r.status = ST_RANGE;
        else r.read_value = held[w.position];
      end
      default: r.status = ST_RANGE;
    endcase
    r.entry_count = held_count[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    iale_out_t exp_w;
    if (!rst_n) begin
      held_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected result word: read_value=%0d entry_count=%0d status=%0d",
                     out_word.read_value, out_word.entry_count, out_word.status);
        end else begin
          exp_w = expected_results.pop_front();
          if (out_word.read_value !== exp_w.read_value ||
              out_word.entry_count !== exp_w.entry_count ||
              out_word.status !== exp_w.status) begin
            errs++;
            if (errs <= 10)
              $display({"mismatch: expected read_value=%0d entry_count=%0d status=%0d, ",
                        "got read_value=%0d entry_count=%0d status=%0d"},
                       exp_w.read_value, exp_w.entry_count, exp_w.status,
                       out_word.read_value, out_word.entry_count, out_word.status);
          end
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(apply_list_request(in_word));
    end
    mismatches  <= errs;
    outstanding <= expected_results.size();
    held_size   <= held_count;
  end

endmodule

### tb/tb.sv
// Top of the indexed array list engine testbench: clock, reset, request stimulus and verdict.
module tb;
  import iale_pkg::*;

  localparam logic [2:0] OP_UNUSED   = 3'd7;
  localparam int         QUIET_LIMIT = 2000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  iale_in_t  in_word;
  logic      out_valid;
  logic      out_stall;
  iale_out_t out_word;

  int mismatches;
  int outstanding;
  int held_size;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int grow_pct       = 40;
  int idle_by_phase  [4] = '{0, 66, 0, 31};
  int stall_by_phase [4] = '{0, 0, 66, 31};
  int grow_by_mode   [3] = '{65, 40, 20};

  indexed_array_list_engine #(.CAPACITY(16)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  iale_result_checker #(.CAPACITY(16)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .held_size   (held_size)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic iale_in_t make_word(input logic [2:0] op, input logic [4:0] pos,
                                         input logic [31:0] val);
    iale_in_t w;
    w.opcode     = op;
    w.position   = pos;
    w.item_value = val;
    return w;
  endfunction

  function automatic iale_in_t random_word(input int grow, input int size);
    iale_in_t w;
    int       r;
    r = $urandom_range(99);
    if (r < 3) begin
      w.opcode = OP_UNUSED;
    end else if (r < grow) begin
      case ($urandom_range(2))
        0:       w.opcode = OP_PUSH_FRONT;
        1:       w.opcode = OP_PUSH_BACK;
        default: w.opcode = OP_INSERT;
      endcase
    end else if (r < 80) begin
      case ($urandom_range(2))
        0:       w.opcode = OP_POP_FRONT;
        1:       w.opcode = OP_POP_BACK;
        default: w.opcode = OP_REMOVE;
      endcase
    end else begin
      w.opcode = OP_READ;
    end
    if ($urandom_range(9) == 0) w.position = 5'($urandom_range(31));
    else w.position = 5'($urandom_range(size));
    case ($urandom_range(9))
      0:       w.item_value = 32'h8000_0000;
      1:       w.item_value = 32'h7fff_ffff;
      2:       w.item_value = 32'h0000_0000;
      3:       w.item_value = 32'hffff_ffff;
      default: w.item_value = $urandom;
    endcase
    return w;
  endfunction

  task automatic send_word(input iale_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    in_valid  <= 1'b0;
    in_word   <= '0;
    rst_n     <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty list corner cases
    send_word(make_word(OP_READ,       5'd0,  32'h1));
    send_word(make_word(OP_POP_FRONT,  5'd0,  32'h0));
    send_word(make_word(OP_POP_BACK,   5'd0,  32'h0));
    send_word(make_word(OP_REMOVE,     5'd0,  32'h0));
    send_word(make_word(OP_INSERT,     5'd1,  32'h2));
    send_word(make_word(OP_UNUSED,     5'd31, 32'hffff_ffff));
    // build up, append via insert at count, insert in the middle
    send_word(make_word(OP_INSERT,     5'd0,  32'h7fff_ffff));
    send_word(make_word(OP_PUSH_FRONT, 5'd31, 32'h8000_0000));
    send_word(make_word(OP_PUSH_BACK,  5'd0,  32'h0));
    send_word(make_word(OP_PUSH_BACK,  5'd16, 32'hffff_ffff));
    send_word(make_word(OP_INSERT,     5'd4,  32'd12345));
    send_word(make_word(OP_INSERT,     5'd2,  32'h5a5a_5a5a));
    send_word(make_word(OP_READ,       5'd0,  32'h0));
    send_word(make_word(OP_READ,       5'd5,  32'h0));
    send_word(make_word(OP_READ,       5'd6,  32'h0));
    send_word(make_word(OP_READ,       5'd31, 32'h0));
    // shrink: remove last, first, past the end
    send_word(make_word(OP_REMOVE,     5'd5,  32'h0));
    send_word(make_word(OP_REMOVE,     5'd0,  32'h0));
    send_word(make_word(OP_REMOVE,     5'd4,  32'h0));
    send_word(make_word(OP_POP_FRONT,  5'd0,  32'h0));
    send_word(make_word(OP_POP_BACK,   5'd0,  32'h0));
    send_word(make_word(OP_READ,       5'd1,  32'h0));
    wait_for_results();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_by_phase[ph];
      recv_stall_pct <= stall_by_phase[ph];
      for (int n = 0; n < 410; n++) begin
        // alternate growing, balanced and shrinking stretches to reach full and empty
        if (n % 40 == 0) grow_pct = grow_by_mode[$urandom_range(2)];
        send_word(random_word(grow_pct, held_size));
      end
      wait_for_results();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
